### rtl/core/cholesky_factorizer_macros.svh
// assertion macros shared by the cholesky factorizer rtl
`ifndef CHOLESKY_FACTORIZER_MACROS_SVH
`define CHOLESKY_FACTORIZER_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define CF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define CF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cf_pkg.sv
// types and constants of the cholesky factorizer
package cf_pkg;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic UNIT_DIV  = 1'b0;
	localparam logic UNIT_SQRT = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         row_index;
		logic [3:0]         col_index;
		logic signed [31:0] cov_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] factor_value;
		logic               not_positive_definite;
	} out_item_t;

	// request to the shared square root / divide unit
	typedef struct packed {
		logic        start;
		logic        op;
		logic [63:0] num;
		logic [31:0] den;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

endpackage

### rtl/core/cf_ram.sv
// generic simple dual-port ram with registered read
module cf_ram import cf_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/cf_sqdiv.sv
// shared iterative unit: 64/32 unsigned divide or 64-bit integer square root
module cf_sqdiv import cf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic [63:0] x_q;
	logic [34:0] rem_q;
	logic [63:0] res_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        op_q;
	logic        busy_q;
	logic        done_q;

	logic [34:0] cand;
	logic [34:0] trial;
	logic        ge;

	always_comb begin
		if (op_q == UNIT_SQRT) begin
			cand  = {rem_q[32:0], x_q[63:62]};
			trial = {1'b0, res_q[31:0], 2'b01};
		end else begin
			cand  = {rem_q[33:0], x_q[63]};
			trial = {3'b000, den_q};
		end
		ge = (cand >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == UNIT_SQRT) ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.num;
			den_q <= req.den;
			op_q  <= req.op;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			x_q   <= (op_q == UNIT_SQRT) ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
			rem_q <= ge ? (cand - trial) : cand;
			res_q <= {res_q[62:0], ge};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

### rtl/core/cholesky_factorizer.sv
// top level of the cholesky factorizer: request handling, sequencer and accumulator
// Loads a covariance matrix one element per load transaction, factors the leading
// n x n block (n = matrix_size, clamped to 1..MAX_ASSETS) into a lower-triangular
// Q8.24 factor on a start transaction, and returns factor entries on read
// transactions. A load returns nothing. A read passes through a ram-read state
// before out_valid rises from a register, the block waits until the result is taken, and it is
// ready again the cycle after that, so no read is accepted while a result waits.
// A start keeps in_ready low for the whole factorization. Each entry (i,j) takes
// fetch, multiply-accumulate and decision steps (one product a cycle through the
// two factor ram read ports), plus the shared iterative unit: a square root on the
// diagonal, a divide below it, or none when a zero entry is stored instead.
// After the last entry one result with the not_positive_definite flag is raised.
// Entries above the diagonal or outside the factored block read as zero; there is
// no clearing pass over the factor store.
`include "cholesky_factorizer_macros.svh"
module cholesky_factorizer import cf_pkg::*; #(
	parameter int MAX_ASSETS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW    = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
	localparam int NW    = $clog2(MAX_ASSETS + 1);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_OUT, S_MAC, S_NUM, S_DECIDE, S_UNIT
	} state_t;

	state_t state_q;

	logic [4:0]    size_q;
	logic [NW-1:0] n_used_q;
	logic          factored_q;
	logic          pivot_err_q;
	logic          rd_zero_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] num_q;
	logic signed [31:0] diag_q;
	logic          v_s1, v_s2;
	logic signed [63:0] prod_s2;
	out_item_t     out_q;
	// set when the decide step wrote a zero entry and the unit is not used
	logic          skip_unit_q;

	logic          accept;
	logic [7:0]    row8, col8, n8, size8, i8;
	logic [AW-1:0] req_addr;

	// ram ports
	logic          cov_we;
	logic [AW-1:0] cov_raddr;
	logic [31:0]   cov_rdata;
	logic          fac_we;
	logic [AW-1:0] fac_waddr;
	logic [31:0]   fac_wdata;
	logic [AW-1:0] fac_raddr_a, fac_raddr_b;
	logic [31:0]   fac_rdata_a, fac_rdata_b;

	unit_req_t unit_req;
	unit_rsp_t unit_rsp;

	// combinational helpers
	logic signed [63:0] cov64, num_diff, acc_sum;
	logic signed [63:0] num_sat, acc_sat;
	logic [63:0]        num_mag;
	logic [31:0]        unit_val;
	logic [NW-1:0]      n_clamp;

	assign accept   = in_valid & in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign row8     = 8'(in_data.row_index);
	assign col8     = 8'(in_data.col_index);
	assign n8       = 8'(n_used_q);
	assign size8    = 8'(size_q);
	assign i8       = 8'(i_q);
	assign req_addr = {row8[IW-1:0], col8[IW-1:0]};

	// matrix_size of zero acts as one, above the store acts as the store size
	always_comb begin
		if (size_q == 5'd0) begin
			n_clamp = NW'(1);
		end else if (size8 > 8'(MAX_ASSETS)) begin
			n_clamp = NW'(MAX_ASSETS);
		end else begin
			n_clamp = NW'(size_q);
		end
	end

	// cov * 2^24 minus the accumulated products, saturating at 64 bits
	assign cov64    = {{8{cov_rdata[31]}}, cov_rdata, 24'd0};
	assign num_diff = cov64 - acc_q;
	always_comb begin
		if ((cov64[63] != acc_q[63]) && (num_diff[63] != cov64[63])) begin
			num_sat = cov64[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			num_sat = num_diff;
		end
	end

	// saturating accumulate of one product
	assign acc_sum = acc_q + prod_s2;
	always_comb begin
		if ((acc_q[63] == prod_s2[63]) && (acc_sum[63] != acc_q[63])) begin
			acc_sat = acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_sat = acc_sum;
		end
	end

	assign num_mag = num_q[63] ? (64'd0 - num_q) : num_q;

	// saturate what the shared unit returns into a Q8.24 entry
	always_comb begin
		if (i_q == j_q) begin
			unit_val = (unit_rsp.result[63:31] != '0) ? 32'h7fff_ffff : unit_rsp.result[31:0];
		end else if (num_q[63]) begin
			if ((unit_rsp.result[63:32] != '0) ||
			    (unit_rsp.result[31] && (unit_rsp.result[30:0] != '0))) begin
				unit_val = 32'h8000_0000;
			end else begin
				unit_val = 32'd0 - unit_rsp.result[31:0];
			end
		end else begin
			unit_val = (unit_rsp.result[63:31] != '0) ? 32'h7fff_ffff : unit_rsp.result[31:0];
		end
	end

	// ram addressing
	always_comb begin
		cov_we      = accept && (in_data.req_type == REQ_LOAD) &&
		              (row8 < 8'(MAX_ASSETS)) && (col8 < 8'(MAX_ASSETS));
		cov_raddr   = {i_q, j_q};
		fac_raddr_a = {i_q, k_q};
		fac_raddr_b = {j_q, k_q};
		if (state_q == S_IDLE) begin
			fac_raddr_a = req_addr;
		end else if ((state_q == S_MAC) && (k_q == j_q)) begin
			// last fetch of an entry: the column's diagonal on port b
			fac_raddr_b = {j_q, j_q};
		end
		fac_waddr = {i_q, j_q};
		fac_we    = 1'b0;
		fac_wdata = unit_val;
		unit_req  = '0;
		unit_req.num = (i_q == j_q) ? num_q : num_mag;
		unit_req.den = diag_q;
		unit_req.op  = (i_q == j_q) ? UNIT_SQRT : UNIT_DIV;
		case (state_q)
			S_DECIDE: begin
				if ((i_q == j_q) ? (num_q <= 0) : (diag_q <= 0)) begin
					fac_we    = 1'b1;
					fac_wdata = '0;
				end else begin
					unit_req.start = 1'b1;
				end
			end
			S_UNIT: begin
				fac_we = unit_rsp.done;
			end
			default: begin
			end
		endcase
	end

	cf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cov_ram (
		.clk(clk), .we(cov_we), .waddr(req_addr), .wdata(in_data.cov_value),
		.raddr(cov_raddr), .rdata(cov_rdata)
	);

	// two copies of the factor store give two reads a cycle
	cf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fac_ram_a (
		.clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
		.raddr(fac_raddr_a), .rdata(fac_rdata_a)
	);

	cf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fac_ram_b (
		.clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
		.raddr(fac_raddr_b), .rdata(fac_rdata_b)
	);

	cf_sqdiv u_sqdiv (
		.clk(clk), .arst_n(arst_n), .req(unit_req), .rsp(unit_rsp)
	);

	// product pipeline: ram data in the cycle after the fetch, then the product registered from it
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(fac_rdata_a) * $signed(fac_rdata_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= 5'd16;
			n_used_q    <= NW'(MAX_ASSETS);
			factored_q  <= 1'b0;
			pivot_err_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_data.req_type)
							REQ_READ: begin
								rd_zero_q <= !factored_q || (row8 >= n8) || (col8 > row8);
								state_q   <= S_RD;
							end
							REQ_START: begin
								n_used_q    <= n_clamp;
								factored_q  <= 1'b1;
								pivot_err_q <= 1'b0;
								i_q         <= '0;
								j_q         <= '0;
								k_q         <= '0;
								acc_q       <= '0;
								state_q     <= S_MAC;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					out_q.factor_value          <= rd_zero_q ? '0 : fac_rdata_a;
					out_q.not_positive_definite <= pivot_err_q;
					out_valid                   <= 1'b1;
					state_q                     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_MAC: begin
					if (v_s2) begin
						acc_q <= acc_sat;
					end
					if (k_q != j_q) begin
						v_s1 <= 1'b1;
						k_q  <= k_q + IW'(1);
					end else if (!v_s1 && !v_s2) begin
						// covariance and diagonal fetched this cycle
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					num_q   <= num_sat;
					diag_q  <= fac_rdata_b;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (fac_we) begin
						if (i_q == j_q) begin
							pivot_err_q <= 1'b1;
						end
						state_q <= S_UNIT;
					end else begin
						state_q <= S_UNIT;
					end
				end
				S_UNIT: begin
					// a zero entry was already written in the decide step
					if (unit_rsp.done || skip_unit_q) begin
						k_q   <= '0;
						acc_q <= '0;
						if (j_q != i_q) begin
							j_q     <= j_q + IW'(1);
							state_q <= S_MAC;
						end else if ((i8 + 8'd1) >= n8) begin
							out_q.factor_value          <= '0;
							out_q.not_positive_definite <= pivot_err_q;
							out_valid                   <= 1'b1;
							state_q                     <= S_OUT;
						end else begin
							i_q     <= i_q + IW'(1);
							j_q     <= '0;
							state_q <= S_MAC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_unit_q <= 1'b0;
		end else begin
			skip_unit_q <= (state_q == S_DECIDE) && fac_we;
		end
	end

	assign out_data = out_q;

	`CF_ASSERT_IMP(a_out_blocks_in, out_valid, !in_ready, "input taken while a result waits")
	`CF_ASSERT_IMP(a_done_in_unit, unit_rsp.done, state_q == S_UNIT, "unit result outside its wait state")
	`CF_ASSERT_NXT(a_start_busy, accept && (in_data.req_type == REQ_START), !in_ready, "start did not hold off input")

endmodule

### dv/tb.sv
// self-checking testbench of the cholesky factorizer
module tb;
	import cf_pkg::*;

	localparam int MAX_ASSETS = 16;
	localparam int CYCLE_LIMIT = 3000000;
	// request code with no meaning, ignored by the block
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	cholesky_factorizer #(.MAX_ASSETS(MAX_ASSETS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	logic signed [31:0] cov_mem [MAX_ASSETS*MAX_ASSETS];
	logic signed [31:0] fac_mem [MAX_ASSETS*MAX_ASSETS];
	logic pivot_flag;
	logic [4:0] size_reg;

	out_item_t pending_q[$];
	int mismatches = 0;
	int cycles = 0;
	bit sender_idle_on;
	bit receiver_idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// saturating 64-bit add and subtract
	function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s;
	endfunction

	function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63])
			s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// row-wise factorization of the leading block
	task automatic factor_matrix();
		int n;
		logic signed [63:0] acc;
		logic signed [63:0] num;
		logic signed [63:0] piv;
		logic [63:0] mag;
		logic [63:0] q;
		n = size_reg;
		if (n < 1) n = 1;
		if (n > MAX_ASSETS) n = MAX_ASSETS;
		foreach (fac_mem[c]) fac_mem[c] = '0;
		pivot_flag = 1'b0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= i; j++) begin
				acc = 0;
				for (int k = 0; k < j; k++)
					acc = add_sat(acc, 64'(fac_mem[i*MAX_ASSETS+k]) *
						64'(fac_mem[j*MAX_ASSETS+k]));
				num = sub_sat(64'(cov_mem[i*MAX_ASSETS+j]) <<< 24, acc);
				if (i == j) begin
					if (num <= 0) begin
						pivot_flag = 1'b1;
						fac_mem[i*MAX_ASSETS+i] = '0;
					end else begin
						q = root_floor(num);
						fac_mem[i*MAX_ASSETS+i] = (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
					end
				end else begin
					piv = 64'(fac_mem[j*MAX_ASSETS+j]);
					if (piv <= 0) begin
						fac_mem[i*MAX_ASSETS+j] = '0;
					end else begin
						mag = num[63] ? -num : num;
						q = mag / piv;
						if (q > 64'h80000000) q = 64'h80000000;
						if (num[63]) fac_mem[i*MAX_ASSETS+j] = -q[31:0];
						else if (q > 64'h7fffffff) fac_mem[i*MAX_ASSETS+j] = 32'h7fffffff;
						else fac_mem[i*MAX_ASSETS+j] = q[31:0];
					end
				end
			end
		end
	endtask

	task automatic predict(in_item_t it);
		out_item_t exp_item;
		case (it.req_type)
			REQ_LOAD: begin
				cov_mem[it.row_index*MAX_ASSETS+it.col_index] = it.cov_value;
			end
			REQ_START: begin
				factor_matrix();
				exp_item.factor_value = '0;
				exp_item.not_positive_definite = pivot_flag;
				pending_q = {pending_q, exp_item};
			end
			REQ_READ: begin
				exp_item.factor_value = (it.col_index <= it.row_index) ?
					fac_mem[it.row_index*MAX_ASSETS+it.col_index] : '0;
				exp_item.not_positive_definite = pivot_flag;
				pending_q = {pending_q, exp_item};
			end
			default: ;
		endcase
	endtask

	// send one transaction, with an optional idle burst before it
	task automatic send_item(in_item_t it);
		if (sender_idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(negedge clk);
		in_valid = 1'b1;
		in_data = it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic in_item_t make_item(logic [1:0] rt, int r, int c, logic [31:0] v);
		in_item_t it;
		it.req_type = rt;
		it.row_index = r[3:0];
		it.col_index = c[3:0];
		it.cov_value = v;
		return it;
	endfunction

	task automatic drain();
		while (pending_q.size() != 0) @(negedge clk);
		// a trailing load may still be in flight
		repeat (8) @(negedge clk);
	endtask

	task automatic set_size(logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		size_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// loads a symmetric matrix, with a large positive diagonal when well_formed is set, mostly positive definite
	task automatic load_matrix(int n, bit well_formed);
		logic [31:0] v;
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				if (i == j) v = well_formed ? 32'($urandom_range(1 << 24, 32'h7000_0000))
					: $urandom;
				else v = well_formed ? 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))
					: $urandom;
				send_item(make_item(REQ_LOAD, i, j, v));
			end
	endtask

	task automatic read_all(int n);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				send_item(make_item(REQ_READ, i, j, $urandom));
	endtask

	// fill the whole store so no start reaches an unwritten entry
	task automatic test_fill();
		for (int i = 0; i < MAX_ASSETS; i++)
			for (int j = 0; j <= i; j++)
				send_item(make_item(REQ_LOAD, i, j, i == j ? 32'h0100_0000 : 32'h0));
	endtask

	task automatic test_directed();
		set_size(5'd0);
		send_item(make_item(REQ_READ, 15, 15, 0));
		send_item(make_item(REQ_UNUSED, 3, 3, 32'hffff_ffff));
		send_item(make_item(REQ_START, 0, 0, 0));
		send_item(make_item(REQ_READ, 0, 0, 0));
		drain();
		set_size(5'd3);
		send_item(make_item(REQ_LOAD, 0, 0, 32'h7fff_ffff));
		send_item(make_item(REQ_LOAD, 1, 0, 32'h8000_0000));
		send_item(make_item(REQ_LOAD, 1, 1, 32'h0));
		send_item(make_item(REQ_LOAD, 2, 0, 32'h7fff_ffff));
		send_item(make_item(REQ_LOAD, 2, 1, 32'h1234_5678));
		send_item(make_item(REQ_LOAD, 2, 2, 32'h8000_0000));
		send_item(make_item(REQ_LOAD, 0, 15, 32'h5555_aaaa));
		send_item(make_item(REQ_START, 0, 0, 0));
		send_item(make_item(REQ_READ, 0, 0, 0));
		send_item(make_item(REQ_READ, 1, 0, 0));
		send_item(make_item(REQ_READ, 2, 1, 0));
		send_item(make_item(REQ_READ, 2, 2, 0));
		send_item(make_item(REQ_READ, 0, 2, 0));
		send_item(make_item(REQ_READ, 5, 5, 0));
		drain();
		send_item(make_item(REQ_LOAD, 1, 0, 32'h0000_0001));
		send_item(make_item(REQ_LOAD, 1, 1, 32'h7fff_ffff));
		send_item(make_item(REQ_START, 0, 0, 0));
		send_item(make_item(REQ_READ, 1, 1, 0));
		drain();
		set_size(5'd31);
	endtask

	task automatic test_random(int count);
		int sent;
		int n;
		logic [3:0] r;
		logic [3:0] c;
		sent = 0;
		while (sent < count) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			drain();
			set_size(5'(n));
			load_matrix(n, $urandom_range(0, 4) != 0);
			sent += n * (n + 1) / 2;
			send_item(make_item(REQ_START, 0, 0, 0));
			for (int k = 0; k < 2 * n + 4; k++) begin
				r = 4'($urandom);
				c = 4'($urandom);
				case ($urandom_range(0, 9))
					0: send_item(make_item(REQ_UNUSED, r, c, $urandom));
					1: send_item(make_item(REQ_LOAD, r, c, $urandom));
					default: send_item(make_item(REQ_READ, r, c, $urandom));
				endcase
			end
			sent += 2 * n + 4;
			if (n <= 6) begin
				read_all(n);
				sent += n * n;
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %h", out_data);
			end else if (pending_q[0] !== out_data) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp value %h flag %b got value %h flag %b",
						pending_q[0].factor_value, pending_q[0].not_positive_definite,
						out_data.factor_value, out_data.not_positive_definite);
				void'(pending_q.pop_front());
			end else begin
				void'(pending_q.pop_front());
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		pivot_flag = 1'b0;
		size_reg = 5'd16;
		foreach (cov_mem[c]) cov_mem[c] = '0;
		foreach (fac_mem[c]) fac_mem[c] = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill();
		test_directed();
		send_item(make_item(REQ_START, 0, 0, 0));
		test_random(300);
		// last part runs with no idling on either side
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		test_random(100);
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
